// ----- sv/reversible_blend_weight_ramp_macros.svh -----
// assertion macros for the blend weight ramp
// used by the top level; no other dependencies
`ifndef REVERSIBLE_BLEND_WEIGHT_RAMP_MACROS_SVH
`define REVERSIBLE_BLEND_WEIGHT_RAMP_MACROS_SVH

// same-cycle implication under synchronous reset
`define RBWR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under synchronous reset
`define RBWR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/rbwr_pkg.sv -----
// shared types and constants for the blend weight ramp
// no dependencies
package rbwr_pkg;

  localparam int TIME_BITS_DEF = 16;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;

  localparam int DELTA_W = 16;
  localparam int NEW_DUR_W = 16;
  localparam int IN_TDATA_W = 40;

  typedef enum logic [1:0] {
    MODE_OFF      = 2'd0,
    MODE_RAMP_ON  = 2'd1,
    MODE_ON       = 2'd2,
    MODE_RAMP_OFF = 2'd3
  } mode_t;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } cmd_t;

endpackage

// ----- sv/reversible_blend_weight_ramp.sv -----
// linear crossfade weight with reversible ramps, built on one shared
// shift-subtract divider and a small sequencer; uses rbwr_pkg and the macro header
// a tick item updates the mode, adds the delta, then sets up the weight and divides
// for it where a ramp needs it; a set item with an active ramp first rescales elapsed
// time by multiply and divide; one item at a time: no new item until the result is taken
// reset (rst_n low, synchronous): mode off, elapsed and duration zero, ready
`include "reversible_blend_weight_ramp_macros.svh"

module reversible_blend_weight_ramp #(
  parameter int TIME_BITS        = rbwr_pkg::TIME_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = rbwr_pkg::WEIGHT_FRAC_BITS_DEF,
  localparam int WW    = WEIGHT_FRAC_BITS + 1,
  localparam int OUT_W = ((WW + 2 + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tick_delta[15:0], target_on[16], new_duration[32:17], zero pad above
  input  logic [rbwr_pkg::IN_TDATA_W-1:0] in_tdata,
  // cmd[0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // weight[WW-1:0], mode[WW+1:WW], zero pad above
  output logic [OUT_W-1:0]                out_tdata
);

  localparam int TB   = TIME_BITS;
  localparam int SW   = (TB > WEIGHT_FRAC_BITS) ? TB : WEIGHT_FRAC_BITS;
  localparam int CW   = $clog2(SW + 1);
  localparam int DW   = (TB > rbwr_pkg::NEW_DUR_W) ? TB : rbwr_pkg::NEW_DUR_W;
  localparam int SUMW = ((TB > rbwr_pkg::DELTA_W) ? TB : rbwr_pkg::DELTA_W) + 1;
  localparam logic [WW-1:0] W_ONE = WW'(1) << WEIGHT_FRAC_BITS;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_TICK_MODE = 9'b000000010,
    S_TICK_ADD  = 9'b000000100,
    S_SET       = 9'b000001000,
    S_MUL       = 9'b000010000,
    S_DIV_SCALE = 9'b000100000,
    S_WGT_SETUP = 9'b001000000,
    S_DIV_WGT   = 9'b010000000,
    S_OUT       = 9'b100000000
  } state_t;

  state_t                state_r, state_nxt;
  rbwr_pkg::mode_t       mode_r, mode_nxt;
  logic [TB-1:0]         elapsed_r, elapsed_nxt;
  logic [TB-1:0]         dur_r, dur_nxt;

  // captured item
  rbwr_pkg::cmd_t        cmd_r;
  logic [rbwr_pkg::DELTA_W-1:0] delta_r;
  logic                  on_r;
  logic [TB-1:0]         new_dur_r;

  // shared divider
  logic [TB:0]           rem_r, rem_nxt;
  logic [SW-1:0]         sh_r, sh_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [2*TB-1:0]       prod_r;
  logic [WW-1:0]         weight_r, weight_nxt;

  logic                  in_fire;
  logic [DW-1:0]         dur_ext;
  logic [TB:0]           rem_shift;
  logic                  rem_ge;
  logic [TB:0]           rem_step;
  logic [SW-1:0]         sh_step;
  logic [TB-1:0]         mirror;
  logic [SUMW-1:0]       sum;
  logic                  ramping;
  logic [WW-1:0]         quot_w;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign dur_ext   = DW'(in_tdata[32:17]);

  // one restoring division step: dividend bits come out of the top of sh,
  // quotient bits go into its bottom
  assign rem_shift = {rem_r[TB-1:0], sh_r[SW-1]};
  assign rem_ge    = (rem_shift >= {1'b0, dur_r});
  assign rem_step  = rem_ge ? (rem_shift - {1'b0, dur_r}) : rem_shift;
  assign sh_step   = {sh_r[SW-2:0], rem_ge};

  assign mirror  = (elapsed_r > dur_r) ? '0 : (dur_r - elapsed_r);
  assign sum     = SUMW'(elapsed_r) + SUMW'(delta_r);
  assign ramping = (mode_r == rbwr_pkg::MODE_RAMP_ON) || (mode_r == rbwr_pkg::MODE_RAMP_OFF);
  assign quot_w  = WW'(sh_step[WEIGHT_FRAC_BITS-1:0]);

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    elapsed_nxt = elapsed_r;
    dur_nxt     = dur_r;
    rem_nxt     = rem_r;
    sh_nxt      = sh_r;
    cnt_nxt     = cnt_r;
    weight_nxt  = weight_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (rbwr_pkg::cmd_t'(in_tuser) == rbwr_pkg::CMD_SET) ? S_SET : S_TICK_MODE;
        end
      end
      S_TICK_MODE: begin
        state_nxt = S_TICK_ADD;
        unique case (mode_r)
          rbwr_pkg::MODE_ON: begin
            if (!on_r) begin
              mode_nxt    = rbwr_pkg::MODE_RAMP_OFF;
              elapsed_nxt = '0;
            end
          end
          rbwr_pkg::MODE_OFF: begin
            if (on_r) begin
              mode_nxt    = rbwr_pkg::MODE_RAMP_ON;
              elapsed_nxt = '0;
            end
          end
          rbwr_pkg::MODE_RAMP_ON: begin
            if (!on_r) begin
              mode_nxt    = rbwr_pkg::MODE_RAMP_OFF;
              elapsed_nxt = mirror;
            end
          end
          rbwr_pkg::MODE_RAMP_OFF: begin
            if (on_r) begin
              mode_nxt    = rbwr_pkg::MODE_RAMP_ON;
              elapsed_nxt = mirror;
            end
          end
          default: begin
            mode_nxt = rbwr_pkg::MODE_OFF;
          end
        endcase
      end
      S_TICK_ADD: begin
        state_nxt = S_WGT_SETUP;
        if (ramping) begin
          if (sum >= SUMW'(dur_r)) begin
            elapsed_nxt = '0;
            mode_nxt    = (mode_r == rbwr_pkg::MODE_RAMP_ON) ? rbwr_pkg::MODE_ON
                                                            : rbwr_pkg::MODE_OFF;
          end else begin
            elapsed_nxt = sum[TB-1:0];
          end
        end
      end
      S_SET: begin
        priority if (new_dur_r == '0) begin
          if (mode_r == rbwr_pkg::MODE_RAMP_ON) begin
            mode_nxt = rbwr_pkg::MODE_ON;
          end else if (mode_r == rbwr_pkg::MODE_RAMP_OFF) begin
            mode_nxt = rbwr_pkg::MODE_OFF;
          end
          dur_nxt   = new_dur_r;
          state_nxt = S_WGT_SETUP;
        end else if (ramping && (dur_r == '0 || elapsed_r > dur_r)) begin
          elapsed_nxt = '0;
          dur_nxt     = new_dur_r;
          state_nxt   = S_WGT_SETUP;
        end else if (ramping) begin
          state_nxt = S_MUL;
        end else begin
          dur_nxt   = new_dur_r;
          state_nxt = S_WGT_SETUP;
        end
      end
      S_MUL: begin
        // product registered; high half is below the old duration
        rem_nxt   = {1'b0, prod_r[2*TB-1:TB]};
        sh_nxt    = SW'(prod_r[TB-1:0]) << (SW - TB);
        cnt_nxt   = CW'(TB);
        state_nxt = S_DIV_SCALE;
      end
      S_DIV_SCALE: begin
        rem_nxt = rem_step;
        sh_nxt  = sh_step;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          elapsed_nxt = sh_step[TB-1:0];
          dur_nxt     = new_dur_r;
          state_nxt   = S_WGT_SETUP;
        end
      end
      S_WGT_SETUP: begin
        state_nxt = S_OUT;
        unique case (mode_r)
          rbwr_pkg::MODE_OFF: weight_nxt = '0;
          rbwr_pkg::MODE_ON:  weight_nxt = W_ONE;
          rbwr_pkg::MODE_RAMP_ON, rbwr_pkg::MODE_RAMP_OFF: begin
            priority if (dur_r == '0 || elapsed_r > dur_r) begin
              weight_nxt = (mode_r == rbwr_pkg::MODE_RAMP_OFF) ? W_ONE : '0;
            end else if (elapsed_r == dur_r) begin
              weight_nxt = (mode_r == rbwr_pkg::MODE_RAMP_OFF) ? '0 : W_ONE;
            end else begin
              rem_nxt   = {1'b0, elapsed_r};
              sh_nxt    = '0;
              cnt_nxt   = CW'(WEIGHT_FRAC_BITS);
              state_nxt = S_DIV_WGT;
            end
          end
          default: weight_nxt = '0;
        endcase
      end
      S_DIV_WGT: begin
        rem_nxt = rem_step;
        sh_nxt  = sh_step;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          weight_nxt = (mode_r == rbwr_pkg::MODE_RAMP_OFF) ? (W_ONE - quot_w) : quot_w;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mode_r    <= rbwr_pkg::MODE_OFF;
      elapsed_r <= '0;
      dur_r     <= '0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      elapsed_r <= elapsed_nxt;
      dur_r     <= dur_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r     <= rbwr_pkg::cmd_t'(in_tuser);
      delta_r   <= in_tdata[15:0];
      on_r      <= in_tdata[16];
      new_dur_r <= dur_ext[TB-1:0];
    end
    rem_r    <= rem_nxt;
    sh_r     <= sh_nxt;
    weight_r <= weight_nxt;
    prod_r   <= (2*TB)'(elapsed_r) * (2*TB)'(new_dur_r);
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = OUT_W'({mode_r, weight_r});

  `RBWR_ASSERT_IMP(a_ready_xor_valid, clk, rst_n, out_tvalid, !in_tready, "ready while result pending")
  `RBWR_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_fire, !in_tready && !out_tvalid, "not busy after accept")
  `RBWR_ASSERT_IMP(a_weight_range, clk, rst_n, out_tvalid, weight_r <= W_ONE, "weight above one")
  `RBWR_ASSERT_IMP(a_off_weight, clk, rst_n, out_tvalid && mode_r == rbwr_pkg::MODE_OFF && cmd_r == rbwr_pkg::CMD_TICK, weight_r == '0, "off mode with nonzero weight")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for the reversible blend weight ramp: directed rows, then random
// fade traffic with random stalls on both sides; depends on rbwr_pkg and the top level
module tb;
  import rbwr_pkg::*;

  localparam logic [16:0] WEIGHT_ONE = 17'h10000;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1250;

  typedef struct packed {
    logic [16:0] weight;
    mode_t       mode;
  } fade_out_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] delta;
    logic        aim_on;
    logic [15:0] dur;
    logic        known;
    logic [16:0] weight;
    mode_t       mode;
  } fade_row_t;

  // typed-in expectations only where known is set; other rows use the fader copy
  localparam int NUM_ROWS = 22;
  localparam fade_row_t FADE_ROWS [NUM_ROWS] = '{
    '{CMD_TICK, 16'h0000, 1'b0, 16'h0000, 1'b1, 17'h0,      MODE_OFF},
    '{CMD_TICK, 16'hffff, 1'b1, 16'h0000, 1'b1, WEIGHT_ONE, MODE_ON},
    '{CMD_TICK, 16'h0000, 1'b0, 16'h0000, 1'b1, 17'h0,      MODE_OFF},
    '{CMD_SET,  16'h0000, 1'b0, 16'hffff, 1'b1, 17'h0,      MODE_OFF},
    '{CMD_TICK, 16'h0000, 1'b1, 16'h0000, 1'b1, 17'h0,      MODE_RAMP_ON},
    '{CMD_TICK, 16'h8000, 1'b1, 16'h0000, 1'b0, 17'h0,      MODE_OFF},
    '{CMD_TICK, 16'h0000, 1'b0, 16'h0000, 1'b0, 17'h0,      MODE_OFF},
    '{CMD_TICK, 16'd100,  1'b1, 16'h0000, 1'b0, 17'h0,      MODE_OFF},
    '{CMD_SET,  16'h0000, 1'b0, 16'd1000, 1'b0, 17'h0,      MODE_OFF},
    '{CMD_SET,  16'h0000, 1'b0, 16'hffff, 1'b0, 17'h0,      MODE_OFF},
    '{CMD_SET,  16'h0000, 1'b0, 16'h0000, 1'b1, WEIGHT_ONE, MODE_ON},
    '{CMD_SET,  16'h0000, 1'b0, 16'h0001, 1'b1, WEIGHT_ONE, MODE_ON},
    '{CMD_TICK, 16'h0000, 1'b0, 16'h0000, 1'b1, WEIGHT_ONE, MODE_RAMP_OFF},
    '{CMD_SET,  16'h0000, 1'b0, 16'h0000, 1'b1, 17'h0,      MODE_OFF},
    '{CMD_SET,  16'h0000, 1'b0, 16'h0003, 1'b1, 17'h0,      MODE_OFF},
    '{CMD_TICK, 16'h0001, 1'b1, 16'h0000, 1'b0, 17'h0,      MODE_OFF},
    '{CMD_TICK, 16'hffff, 1'b1, 16'h0000, 1'b1, WEIGHT_ONE, MODE_ON},
    '{CMD_SET,  16'h0000, 1'b0, 16'hffff, 1'b1, WEIGHT_ONE, MODE_ON},
    '{CMD_TICK, 16'hfffe, 1'b0, 16'h0000, 1'b0, 17'h0,      MODE_OFF},
    '{CMD_TICK, 16'h0001, 1'b0, 16'h0000, 1'b1, 17'h0,      MODE_OFF},
    '{CMD_SET,  16'hffff, 1'b1, 16'h1234, 1'b1, 17'h0,      MODE_OFF},
    '{CMD_TICK, 16'h0005, 1'b1, 16'hffff, 1'b0, 17'h0,      MODE_OFF}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  // fader state as the bench sees it
  mode_t       fader_mode = MODE_OFF;
  logic [15:0] fader_elapsed = '0;
  logic [15:0] fader_duration = '0;

  fade_out_t   pending_weights [$];
  int          fail_count = 0;
  int          tick_count = 0;
  int          set_count = 0;
  int          weights_checked = 0;
  int          idle_cycles = 0;
  int          rx_hold = 0;
  bit          calm = 1'b0;
  logic        aim = 1'b0;

  reversible_blend_weight_ramp DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [15:0] mirror_time();
    return (fader_elapsed > fader_duration) ? 16'h0 : fader_duration - fader_elapsed;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // advance the fader copy by one item and return the weight it reports
  function automatic fade_out_t advance_fader(cmd_t cmd, logic [15:0] delta, logic aim_on,
                                              logic [15:0] dur);
    logic [16:0] sum;
    logic [32:0] quot;
    fade_out_t   res;
    if (cmd == CMD_TICK) begin
      case (fader_mode)
        MODE_ON: if (!aim_on) begin
          fader_mode = MODE_RAMP_OFF;
          fader_elapsed = '0;
        end
        MODE_OFF: if (aim_on) begin
          fader_mode = MODE_RAMP_ON;
          fader_elapsed = '0;
        end
        MODE_RAMP_ON: if (!aim_on) begin
          fader_mode = MODE_RAMP_OFF;
          fader_elapsed = mirror_time();
        end
        default: if (aim_on) begin
          fader_mode = MODE_RAMP_ON;
          fader_elapsed = mirror_time();
        end
      endcase
      if (fader_mode == MODE_RAMP_ON || fader_mode == MODE_RAMP_OFF) begin
        sum = {1'b0, fader_elapsed} + {1'b0, delta};
        if (sum >= {1'b0, fader_duration}) begin
          fader_elapsed = '0;
          fader_mode = (fader_mode == MODE_RAMP_ON) ? MODE_ON : MODE_OFF;
        end else begin
          fader_elapsed = sum[15:0];
        end
      end
    end else begin
      if (dur == 16'h0) begin
        if (fader_mode == MODE_RAMP_ON) fader_mode = MODE_ON;
        else if (fader_mode == MODE_RAMP_OFF) fader_mode = MODE_OFF;
      end else if (fader_mode == MODE_RAMP_ON || fader_mode == MODE_RAMP_OFF) begin
        if (fader_duration == 16'h0 || fader_elapsed > fader_duration) begin
          fader_elapsed = '0;
        end else begin
          quot = ({17'h0, fader_elapsed} * {17'h0, dur}) / {17'h0, fader_duration};
          fader_elapsed = quot[15:0];
        end
      end
      fader_duration = dur;
    end

    res.mode = fader_mode;
    if (fader_mode == MODE_ON) begin
      res.weight = WEIGHT_ONE;
    end else if (fader_mode == MODE_OFF) begin
      res.weight = '0;
    end else begin
      if (fader_duration == 16'h0 || fader_elapsed > fader_duration) quot = '0;
      else quot = {1'b0, fader_elapsed, 16'h0} / {17'h0, fader_duration};
      if (fader_mode == MODE_RAMP_OFF) quot = {16'h0, WEIGHT_ONE} - quot;
      res.weight = quot[16:0];
    end
    return res;
  endfunction

  // present one item and hold it until accepted; valid stays high for the caller
  task automatic send_item(cmd_t cmd, logic [15:0] delta, logic aim_on, logic [15:0] dur,
                           logic known, fade_out_t typed);
    fade_out_t predicted;
    in_tdata  <= {7'h0, dur, aim_on, delta};
    in_tuser  <= cmd;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = advance_fader(cmd, delta, aim_on, dur);
    pending_weights.push_back(known ? typed : predicted);
    if (cmd == CMD_TICK) tick_count++;
    else set_count++;
  endtask

  task automatic pause_sender();
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_item();
    int          r;
    cmd_t        cmd;
    logic [15:0] delta;
    logic [15:0] dur;
    logic [15:0] span;
    fade_out_t   unused;
    unused = '0;
    delta  = 16'($urandom_range(0, 65535));
    dur    = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (r < 12) begin
      cmd = CMD_SET;
      r = $urandom_range(0, 99);
      if (r < 10) dur = '0;
      else if (r < 70) dur = 16'($urandom_range(1, 64));
      else if (r < 90) dur = 16'($urandom_range(65, 4000));
    end else begin
      cmd = CMD_TICK;
      if ($urandom_range(0, 99) < 25) aim = ~aim;
      span = (fader_duration >> 2) + 16'd1;
      r = $urandom_range(0, 99);
      if (r < 15) delta = '0;
      else if (r < 70) delta = 16'($urandom_range(1, span));
      else if (r < 85) delta = 16'($urandom_range(1, 300));
      else if (r < 90) delta = 16'hffff;
    end
    // ignored fields still carry random bits
    send_item(cmd, delta, (cmd == CMD_TICK) ? aim : logic'($urandom_range(0, 1)), dur,
              1'b0, unused);
  endtask

  always @(posedge clk) begin
    fade_out_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_weights.size() == 0) begin
          $error("result with nothing expected: weight %0d mode %0d",
                 out_tdata[16:0], out_tdata[18:17]);
          fail_count++;
        end else begin
          want = pending_weights.pop_front();
          weights_checked++;
          if (out_tdata[16:0] !== want.weight) begin
            $error("weight: expected %0d, got %0d", want.weight, out_tdata[16:0]);
            fail_count++;
          end
          if (out_tdata[18:17] !== want.mode) begin
            $error("mode: expected %0d, got %0d", want.mode, out_tdata[18:17]);
            fail_count++;
          end
        end
      end
      if (rx_hold != 0) begin
        out_tready <= 1'b0;
        rx_hold <= rx_hold - 1;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        out_tready <= 1'b0;
        rx_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 60) : $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    fade_out_t typed;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      typed.weight = FADE_ROWS[i].weight;
      typed.mode   = FADE_ROWS[i].mode;
      send_item(FADE_ROWS[i].cmd, FADE_ROWS[i].delta, FADE_ROWS[i].aim_on, FADE_ROWS[i].dur,
                FADE_ROWS[i].known, typed);
      pause_sender();
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = ((i % 200) >= 100) && ((i % 200) < 150);
      random_item();
      pause_sender();
      if (i == RANDOM_ITEMS / 2) begin
        // let the block drain completely once
        in_tvalid <= 1'b0;
        while (pending_weights.size() != 0) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    while (pending_weights.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("sent %0d ticks and %0d duration changes, %0d weights checked",
             tick_count, set_count, weights_checked);
    $display("covered ramps, reversals, rescales and zero-duration finishes under stalls");
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
